// ----- design/sbhc_pkg.sv -----
// ----------------------------------------------------------------------------
// sbhc_pkg: shared types and constants for the spectrum bin heatmap colorizer
// Payload structs, register indexes, reset values, fixed-point widths and
// the sample magnitude / prescale helpers.
// ----------------------------------------------------------------------------
package sbhc_pkg;

  localparam int SAMPLE_WIDTH = 32;

  localparam int SHIFT_MAX = (SAMPLE_WIDTH > 31) ? SAMPLE_WIDTH - 31 : 0;
  localparam int SHIFT_W   = (SHIFT_MAX > 0) ? $clog2(SHIFT_MAX + 1) : 1;
  localparam int MAG_W     = (SAMPLE_WIDTH > 31) ? SAMPLE_WIDTH : 31;
  localparam int SQ_W      = 31;
  localparam int POWER_W   = 2 * SQ_W + 1;

  localparam int NORM_STEPS = 6;
  localparam int CNT_W      = 4;
  localparam int LZ_W       = 6;
  localparam int FRAC_W     = 16;
  localparam int MANT_W     = 32;
  localparam int LOG_INT_W  = $clog2(POWER_W + 2 * SHIFT_MAX + 1);
  localparam int LOG_W      = LOG_INT_W + FRAC_W;

  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;

  localparam int LEVEL_W  = 20;
  localparam int AVG_W    = 32;
  localparam int OFFSET_W = 17;
  localparam int WEIGHT_W = 16;
  localparam int GAIN_W   = 4;
  localparam int DB_W     = 18;
  localparam int RND_W    = 42;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 17;

  localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_OFFSET     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SMOOTHING_WEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CONTRAST_GAIN    = 2'd2;

  localparam logic signed [OFFSET_W-1:0] LEVEL_OFFSET_RESET     = -17'sd16953;
  localparam logic        [WEIGHT_W-1:0] SMOOTHING_WEIGHT_RESET = 16'd66;
  localparam logic        [GAIN_W-1:0]   CONTRAST_GAIN_RESET    = 4'd5;
  localparam logic signed [AVG_W-1:0]    AVG_RESET              = -32'sd6553600;
  localparam logic signed [LEVEL_W-1:0]  LEVEL_FLOOR            = -20'sd61440;

  localparam logic [DB_W-1:0]  DB_PER_LOG2 = 18'd197283;
  localparam logic [RND_W-1:0] DB_ROUND    = 42'h000_0080_0000;
  localparam logic [LZ_W-1:0]  NORM_FIRST  = 6'd32;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] bin_real;
    logic signed [SAMPLE_WIDTH-1:0] bin_imag;
  } bin_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] color_level;
  } pixel_t;

  function automatic logic [MAG_W-1:0] sample_mag(input logic [SAMPLE_WIDTH-1:0] v);
    logic [SAMPLE_WIDTH-1:0] u;
    u = v[SAMPLE_WIDTH-1] ? (~v + 1'b1) : v;
    return MAG_W'(u);
  endfunction

  // right shift that brings the larger magnitude below 2^31
  function automatic logic [SHIFT_W-1:0] scale_shift(input logic [MAG_W-1:0] big);
    logic [SHIFT_W-1:0] s;
    s = '0;
    for (int i = SQ_W; i < MAG_W; i++) begin
      if (big[i]) begin
        s = SHIFT_W'(i - SQ_W + 1);
      end
    end
    return s;
  endfunction

endpackage

// ----- design/spectrum_bin_heatmap_colorizer_top.sv -----
// ----------------------------------------------------------------------------
// spectrum_bin_heatmap_colorizer_top: spectrum bin to heatmap pixel
// Each complex bin becomes one pixel: dB level via an iterative log2,
// noise-floor tracking and a black-blue-green-red palette.
//
// Channels: bin (valid/ready, bin_t) in, pixel (valid/ready, pixel_t) out,
// cfg (valid/ready, index and data) for level_offset, smoothing_weight and
// contrast_gain; cfg is always ready, writes to unknown indexes are dropped.
// A zero-power bin skips the normalize, the log2 and the dB steps. One bin is
// worked on at a time; the next is taken only after its pixel is handed on.
// All products go through the single shared multiplier: 16 log2 mantissa
// squarings and five more products, after a 6-step normalize.
// bin_ready is high only while the sequencer is idle.
// The pixel sits in an output register, so the next bin is taken while a
// pixel waits; if the receiver stalls, a finished pixel holds in the
// sequencer until the output register frees up.
// Reset: registers return to their defaults, the noise floor to -100 dB,
// the output register empties.
// ----------------------------------------------------------------------------
module spectrum_bin_heatmap_colorizer_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                bin_valid,
  output logic                                bin_ready,
  input  sbhc_pkg::bin_t                      bin_data,
  output logic                                pixel_valid,
  input  logic                                pixel_ready,
  output sbhc_pkg::pixel_t                    pixel_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sbhc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sbhc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sbhc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCALE, S_SQ_RE, S_SQ_IM, S_SUM, S_NORM, S_LOG_MUL, S_LOG_UPD,
    S_DB_MUL, S_DB_UPD, S_AVG_MUL, S_AVG_UPD, S_GAIN_MUL, S_GAIN_UPD, S_DONE
  } state_t;

  state_t                      state;
  logic signed [OFFSET_W-1:0]  level_offset;
  logic [WEIGHT_W-1:0]         smoothing_weight;
  logic [GAIN_W-1:0]           contrast_gain;
  logic signed [AVG_W-1:0]     noise_floor_avg;

  logic [MAG_W-1:0]            mag_re;
  logic [MAG_W-1:0]            mag_im;
  logic [SHIFT_W-1:0]          shift;
  logic [SQ_W-1:0]             a_sh;
  logic [SQ_W-1:0]             b_sh;
  logic [POWER_W-1:0]          psum;
  logic [POWER_W-1:0]          work;
  logic [LZ_W-1:0]             lz;
  logic [CNT_W-1:0]            cnt;
  logic [MANT_W-1:0]           m;
  logic [FRAC_W-1:0]           frac;
  logic signed [LEVEL_W-1:0]   level;
  logic [7:0]                  clvl;

  logic signed [MUL_W-1:0]     mul_a;
  logic signed [MUL_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]    prod;
  pixel_t                      pixel_next;

  logic [MAG_W-1:0]            big;
  logic [SHIFT_W-1:0]          shift_next;
  logic [MAG_W-1:0]            re_shifted;
  logic [MAG_W-1:0]            im_shifted;
  logic [POWER_W-1:0]          power;
  logic [LZ_W-1:0]             norm_sh;
  logic                        top_zero;
  logic [POWER_W-1:0]          work_next;
  logic [LZ_W-1:0]             lz_next;
  logic [MANT_W:0]             sq;
  logic [LOG_INT_W-1:0]        log_int;
  logic [LOG_W-1:0]            log2q;
  logic [RND_W-1:0]            rnd;
  logic signed [LEVEL_W-1:0]   level_sum;
  logic signed [MUL_W-1:0]     diff;
  logic [7:0]                  clvl_next;

  assign bin_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  sbhc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  sbhc_color u_color (
    .color_level (clvl),
    .pixel       (pixel_next)
  );

  always_comb begin
    big        = (mag_re > mag_im) ? mag_re : mag_im;
    shift_next = scale_shift(big);
    re_shifted = mag_re >> shift_next;
    im_shifted = mag_im >> shift_next;

    power = psum + prod[POWER_W-1:0];

    // binary-search normalize: 32, 16, 8, 4, 2, 1
    norm_sh   = NORM_FIRST >> cnt[2:0];
    top_zero  = (work & ~({POWER_W{1'b1}} >> norm_sh)) == '0;
    work_next = top_zero ? (work << norm_sh) : work;
    lz_next   = top_zero ? (lz + norm_sh) : lz;

    sq = prod[2*MANT_W-1:MANT_W-1];

    log_int = LOG_INT_W'(POWER_W - 1) - LOG_INT_W'(lz) + LOG_INT_W'({shift, 1'b0});
    log2q   = {log_int, frac};

    rnd       = prod[RND_W-1:0] + DB_ROUND;
    level_sum = $signed({{(LEVEL_W-DB_W){1'b0}}, rnd[RND_W-1:RND_W-DB_W]})
                + LEVEL_W'(level_offset);

    diff = $signed({{(MUL_W-LEVEL_W-8){level[LEVEL_W-1]}}, level, 8'b0})
           - $signed({{(MUL_W-AVG_W){noise_floor_avg[AVG_W-1]}}, noise_floor_avg});

    if (prod[PROD_W-1] || prod == '0) begin
      clvl_next = 8'd0;
    end else if (prod[PROD_W-2:24] != '0) begin
      clvl_next = 8'd255;
    end else begin
      clvl_next = prod[23:16];
    end
  end

  always_comb begin
    case (state)
      S_SQ_RE: begin
        mul_a = $signed({{(MUL_W-SQ_W){1'b0}}, a_sh});
        mul_b = $signed({{(MUL_W-SQ_W){1'b0}}, a_sh});
      end
      S_SQ_IM: begin
        mul_a = $signed({{(MUL_W-SQ_W){1'b0}}, b_sh});
        mul_b = $signed({{(MUL_W-SQ_W){1'b0}}, b_sh});
      end
      S_LOG_MUL: begin
        mul_a = $signed({{(MUL_W-MANT_W){1'b0}}, m});
        mul_b = $signed({{(MUL_W-MANT_W){1'b0}}, m});
      end
      S_DB_MUL: begin
        mul_a = $signed({{(MUL_W-LOG_W){1'b0}}, log2q});
        mul_b = $signed({{(MUL_W-DB_W){1'b0}}, DB_PER_LOG2});
      end
      S_AVG_MUL: begin
        mul_a = diff;
        mul_b = $signed({{(MUL_W-WEIGHT_W){1'b0}}, smoothing_weight});
      end
      S_GAIN_MUL: begin
        mul_a = diff;
        mul_b = $signed({{(MUL_W-GAIN_W){1'b0}}, contrast_gain});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      pixel_valid      <= 1'b0;
      level_offset     <= LEVEL_OFFSET_RESET;
      smoothing_weight <= SMOOTHING_WEIGHT_RESET;
      contrast_gain    <= CONTRAST_GAIN_RESET;
      noise_floor_avg  <= AVG_RESET;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_LEVEL_OFFSET:     level_offset     <= $signed(cfg_data);
          CFG_SMOOTHING_WEIGHT: smoothing_weight <= cfg_data[WEIGHT_W-1:0];
          CFG_CONTRAST_GAIN:    contrast_gain    <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end

      if (state == S_DONE && (!pixel_valid || pixel_ready)) begin
        pixel_valid <= 1'b1;
      end else if (pixel_ready) begin
        pixel_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (bin_valid) begin
            mag_re <= sample_mag(bin_data.bin_real);
            mag_im <= sample_mag(bin_data.bin_imag);
            state  <= S_SCALE;
          end
        end
        S_SCALE: begin
          shift <= shift_next;
          a_sh  <= re_shifted[SQ_W-1:0];
          b_sh  <= im_shifted[SQ_W-1:0];
          state <= S_SQ_RE;
        end
        S_SQ_RE: begin
          state <= S_SQ_IM;
        end
        S_SQ_IM: begin
          psum  <= prod[POWER_W-1:0];
          state <= S_SUM;
        end
        S_SUM: begin
          work <= power;
          lz   <= '0;
          cnt  <= '0;
          if (power == '0) begin
            level <= LEVEL_FLOOR;
            state <= S_AVG_MUL;
          end else begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          work <= work_next;
          lz   <= lz_next;
          if (cnt == CNT_W'(NORM_STEPS - 1)) begin
            m     <= work_next[POWER_W-1:POWER_W-MANT_W];
            cnt   <= '0;
            state <= S_LOG_MUL;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_LOG_MUL: begin
          state <= S_LOG_UPD;
        end
        S_LOG_UPD: begin
          if (sq[MANT_W]) begin
            m    <= sq[MANT_W:1];
            frac <= {frac[FRAC_W-2:0], 1'b1};
          end else begin
            m    <= sq[MANT_W-1:0];
            frac <= {frac[FRAC_W-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(FRAC_W - 1)) begin
            state <= S_DB_MUL;
          end else begin
            state <= S_LOG_MUL;
          end
        end
        S_DB_MUL: begin
          state <= S_DB_UPD;
        end
        S_DB_UPD: begin
          level <= (level_sum < LEVEL_FLOOR) ? LEVEL_FLOOR : level_sum;
          state <= S_AVG_MUL;
        end
        S_AVG_MUL: begin
          state <= S_AVG_UPD;
        end
        S_AVG_UPD: begin
          noise_floor_avg <= noise_floor_avg + AVG_W'(prod >>> 16);
          state           <= S_GAIN_MUL;
        end
        S_GAIN_MUL: begin
          state <= S_GAIN_UPD;
        end
        S_GAIN_UPD: begin
          clvl  <= clvl_next;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!pixel_valid || pixel_ready) begin
            pixel_data  <= pixel_next;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/sbhc_mul.sv -----
// ----------------------------------------------------------------------------
// sbhc_mul: shared signed multiplier
// One signed multiply per cycle with a registered product, reused for the
// power squares, the log mantissa squares, dB scaling, averaging and gain.
// ----------------------------------------------------------------------------
module sbhc_mul (
  input  logic                                 clk,
  input  logic signed [sbhc_pkg::MUL_W-1:0]    a,
  input  logic signed [sbhc_pkg::MUL_W-1:0]    b,
  output logic signed [sbhc_pkg::PROD_W-1:0]   prod
);
  import sbhc_pkg::*;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ----- design/sbhc_color.sv -----
// ----------------------------------------------------------------------------
// sbhc_color: heatmap palette
// Maps a 0..255 level onto the black-blue-green-red ramp.
// ----------------------------------------------------------------------------
module sbhc_color (
  input  logic [7:0]       color_level,
  output sbhc_pkg::pixel_t pixel
);
  import sbhc_pkg::*;

  logic [7:0] up4;
  logic [7:0] up2;

  assign up4 = {color_level[5:0], 2'b00};
  assign up2 = {1'b0, color_level[5:0], 1'b0};

  always_comb begin
    pixel.color_level = color_level;
    pixel.red   = 8'd0;
    pixel.green = 8'd0;
    pixel.blue  = 8'd0;
    if (color_level < 8'd64) begin
      pixel.blue = up4;
    end else if (color_level < 8'd128) begin
      pixel.blue  = 8'd255;
      pixel.green = up4;
    end else if (color_level < 8'd192) begin
      pixel.green = 8'd255;
      pixel.blue  = 8'd255 - up4;
      pixel.red   = up2;
    end else begin
      pixel.red   = 8'd255;
      pixel.green = 8'd255 - up4;
    end
  end

endmodule
